[src/sgc_pkg.sv]
// Shared types, constants and dial quantisers for the servo gauge clock.
package sgc_pkg;

    localparam int unsigned DIAL_W       = 10;
    localparam int unsigned COUNT_W      = 17;
    localparam int unsigned ANGLE_W      = 8;
    localparam int unsigned MASK_W       = 3;
    localparam int unsigned HOUR_W       = 5;
    localparam int unsigned MINSEC_W     = 6;

    localparam logic [HOUR_W-1:0]   LAST_HOUR     = 5'd23;
    localparam logic [HOUR_W-1:0]   DAY_HOURS     = 5'd24;
    localparam logic [MINSEC_W-1:0] LAST_MINSEC   = 6'd59;
    localparam logic [MINSEC_W-1:0] FULL_MINSEC   = 6'd60;
    localparam logic [COUNT_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [COUNT_W-1:0]  SECS_PER_MIN  = 17'd60;
    localparam logic [COUNT_W-1:0]  SECS_PER_DAY  = 17'd86400;

    localparam logic [MASK_W-1:0] MASK_ALL     = 3'b111;
    localparam logic [MASK_W-1:0] MASK_SECONDS = 3'b001;
    localparam logic [MASK_W-1:0] MASK_MINUTES = 3'b010;
    localparam logic [MASK_W-1:0] MASK_HOURS   = 3'b100;

    typedef enum logic [1:0] {
        MODE_RUNNING     = 2'd0,
        MODE_SET_HOURS   = 2'd1,
        MODE_SET_MINUTES = 2'd2,
        MODE_SET_SECONDS = 2'd3
    } mode_t;

    typedef struct packed {
        logic              button_level;
        logic [DIAL_W-1:0] dial_sample;
    } pass_word_t;

    typedef struct packed {
        logic [1:0]         clock_mode;
        logic [COUNT_W-1:0] time_count;
        logic [ANGLE_W-1:0] seconds_angle;
        logic [ANGLE_W-1:0] minutes_angle;
        logic [ANGLE_W-1:0] hours_angle;
        logic [MASK_W-1:0]  angle_write_mask;
    } result_word_t;

    // Dial scaled to 0..24 with rounding: (d*24 + 512) >> 10.
    function automatic logic [HOUR_W-1:0] quantise_hours(input logic [DIAL_W-1:0] d);
        logic [14:0] scaled;
        begin
            scaled = 15'(d) * 15'd24 + 15'd512;
            return scaled[14:10];
        end
    endfunction

    // Dial scaled to 0..60 with rounding: (d*60 + 512) >> 10.
    function automatic logic [MINSEC_W-1:0] quantise_minsec(input logic [DIAL_W-1:0] d);
        logic [15:0] scaled;
        begin
            scaled = 16'(d) * 16'd60 + 16'd512;
            return scaled[15:10];
        end
    endfunction

endpackage

[src/sgc_input_stage.sv]
// Input register holding one accepted pass word until the time core takes it.
module sgc_input_stage
    import sgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pass_valid,
    output logic       pass_ready,
    input  pass_word_t pass_word,
    input  logic       take,
    output logic       full,
    output pass_word_t held_word
);

    logic       full_reg;
    logic       full_next;
    pass_word_t word_reg;

    assign pass_ready = !full_reg || take;
    assign full_next  = (pass_valid && pass_ready) || (full_reg && !take);
    assign full       = full_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_valid && pass_ready)
        begin
            word_reg <= pass_word;
        end
    end

endmodule

[src/sgc_time_core.sv]
// Mode register, hours/minutes/seconds registers and the per-pass update logic.
module sgc_time_core
    import sgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  pass_word_t   word,
    output result_word_t result
);

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [HOUR_W-1:0]    hh_reg;
    logic [HOUR_W-1:0]    hh_next;
    logic [MINSEC_W-1:0]  mm_reg;
    logic [MINSEC_W-1:0]  mm_next;
    logic [MINSEC_W-1:0]  ss_reg;
    logic [MINSEC_W-1:0]  ss_next;
    logic [HOUR_W-1:0]    q_hours;
    logic [MINSEC_W-1:0]  q_minsec;
    logic [HOUR_W-1:0]    hh_plus;
    logic [MINSEC_W-1:0]  mm_plus;
    logic [HOUR_W-1:0]    hh_after_mm;
    logic [8:0]           hours_set_x15;
    logic [6:0]           hours_run_x5;
    logic [ANGLE_W-1:0]   sa;
    logic [ANGLE_W-1:0]   ma;
    logic [ANGLE_W-1:0]   ha;
    logic [MASK_W-1:0]    mask;
    logic [COUNT_W-1:0]   count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RUNNING;
            hh_reg   <= '0;
            mm_reg   <= '0;
            ss_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            hh_reg   <= hh_next;
            mm_reg   <= mm_next;
            ss_reg   <= ss_next;
        end
    end

    assign q_hours  = quantise_hours(word.dial_sample);
    assign q_minsec = quantise_minsec(word.dial_sample);

    // Carry helpers: the next hour wraps at midnight, the minute carries into it.
    assign hh_plus     = (hh_reg == LAST_HOUR) ? '0 : hh_reg + HOUR_W'(1);
    assign mm_plus     = (mm_reg == LAST_MINSEC) ? '0 : mm_reg + MINSEC_W'(1);
    assign hh_after_mm = (mm_reg == LAST_MINSEC) ? hh_plus : hh_reg;

    assign hours_set_x15 = 9'(q_hours) * 9'd15;
    assign hours_run_x5  = 7'(hh_reg) * 7'd5;

    always_comb
    begin
        mode_next = word.button_level ? mode_t'(mode_reg + 2'd1) : mode_reg;
        hh_next   = hh_reg;
        mm_next   = mm_reg;
        ss_next   = ss_reg;
        sa        = '0;
        ma        = '0;
        ha        = '0;
        mask      = '0;
        unique case (mode_next)
            MODE_RUNNING:
            begin
                sa   = ANGLE_W'(8'(ss_reg) * 8'd3);
                ma   = ANGLE_W'(8'(mm_reg) * 8'd3);
                ha   = ANGLE_W'(hours_run_x5[6:1]);
                mask = MASK_ALL;
                if (ss_reg == LAST_MINSEC)
                begin
                    ss_next = '0;
                    mm_next = mm_plus;
                    hh_next = hh_after_mm;
                end
                else
                begin
                    ss_next = ss_reg + MINSEC_W'(1);
                end
            end
            MODE_SET_HOURS:
            begin
                ha      = hours_set_x15[8:1];
                mask    = MASK_HOURS;
                hh_next = (q_hours == DAY_HOURS) ? '0 : q_hours;
            end
            MODE_SET_MINUTES:
            begin
                ma   = ANGLE_W'(8'(q_minsec) * 8'd3);
                mask = MASK_MINUTES;
                // A full sixty minutes rolls over into the next hour.
                if (q_minsec == FULL_MINSEC)
                begin
                    mm_next = '0;
                    hh_next = hh_plus;
                end
                else
                begin
                    mm_next = q_minsec;
                end
            end
            MODE_SET_SECONDS:
            begin
                sa   = ANGLE_W'(8'(q_minsec) * 8'd3);
                mask = MASK_SECONDS;
                if (q_minsec == FULL_MINSEC)
                begin
                    ss_next = '0;
                    mm_next = mm_plus;
                    hh_next = hh_after_mm;
                end
                else
                begin
                    ss_next = q_minsec;
                end
            end
            default:
            begin
                mask = '0;
            end
        endcase
    end

    assign count = COUNT_W'(hh_next) * SECS_PER_HOUR
                 + COUNT_W'(mm_next) * SECS_PER_MIN
                 + COUNT_W'(ss_next);

    assign result.clock_mode       = mode_next;
    assign result.time_count       = count;
    assign result.seconds_angle    = sa;
    assign result.minutes_angle    = ma;
    assign result.hours_angle      = ha;
    assign result.angle_write_mask = mask;

endmodule

[src/sgc_output_stage.sv]
// Result register that holds one finished word until the receiver takes it.
module sgc_output_stage
    import sgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_word_t load_word,
    output logic         space,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result_word
);

    logic         valid_reg;
    logic         valid_next;
    result_word_t word_reg;

    assign space        = !valid_reg || result_ready;
    assign valid_next   = load || (valid_reg && !result_ready);
    assign result_valid = valid_reg;
    assign result_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

endmodule

[src/servo_gauge_clock_with_set_modes_core.sv]
// Servo gauge clock: one loop pass in, hand angles and time of day out.
//
// The pass channel carries one word per loop pass: the button level and a
// 10-bit dial sample. The result channel returns exactly one word per pass:
// the mode after the pass, the seconds counter, the three hand angles and a
// mask of the angles written. Both channels use valid/ready handshakes.
// A pass word is captured in an input register; when the output register has
// space, the mode and time registers update and the result is captured in the
// output register. Throughput is one word per cycle while the receiver is
// ready: the time update is a single pass of short logic from the input
// register to the output register, with the mode and hours/minutes/seconds
// registers closing the only loop.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more pass word; further words wait on ready.
// Reset clears the time to midnight, selects running mode and empties both
// registers.
module servo_gauge_clock_with_set_modes_core
    import sgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pass_valid,
    output logic         pass_ready,
    input  pass_word_t   pass_word,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result_word
);

    logic         in_full;
    logic         out_space;
    logic         advance;
    pass_word_t   held_word;
    result_word_t next_result;

    assign advance = in_full && out_space;

    sgc_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pass_valid (pass_valid),
        .pass_ready (pass_ready),
        .pass_word  (pass_word),
        .take       (advance),
        .full       (in_full),
        .held_word  (held_word)
    );

    sgc_time_core u_time_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (held_word),
        .result (next_result)
    );

    sgc_output_stage u_output_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .load_word    (next_result),
        .space        (out_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    // Running passes write all three hands; set passes write exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result_word.clock_mode == MODE_RUNNING) ?
                (result_word.angle_write_mask == MASK_ALL) :
                $onehot(result_word.angle_write_mask)))
        else $error("angle write mask does not match mode");

    // The counter always stays within one day.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_word.time_count < SECS_PER_DAY))
        else $error("time count out of range");

    // An accepted pass word must be waiting in the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pass_valid && pass_ready) |=> in_full)
        else $error("accepted pass word was lost");

    // A result word appears the cycle after the time core steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("stepped pass produced no result");

endmodule

[tb/servo_gauge_clock_with_set_modes_core_tb.sv]
// Self-checking testbench for the servo gauge clock core: directed table, random passes.
module servo_gauge_clock_with_set_modes_core_tb;
    import sgc_pkg::*;

    localparam int unsigned RANDOM_PASSES = 1500;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;

    typedef struct {
        pass_word_t   word;
        bit           typed;
        result_word_t want;
    } step_row_t;

    localparam result_word_t NO_WANT = '0;

    logic         clk;
    logic         rst_n;
    logic         pass_valid;
    logic         pass_ready;
    pass_word_t   pass_word;
    logic         result_valid;
    logic         result_ready;
    result_word_t result_word;

    // Behavioural copy of the clock state, advanced on every accepted word.
    logic [COUNT_W-1:0] model_secs;
    mode_t              model_mode;

    result_word_t pending_results[$];
    int unsigned  mismatch_count;
    int unsigned  pass_gap_pct;
    int unsigned  result_stall_pct;
    int unsigned  quiet_cycles;
    step_row_t    steps[];

    servo_gauge_clock_with_set_modes_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pass_valid   (pass_valid),
        .pass_ready   (pass_ready),
        .pass_word    (pass_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    always #5 clk = ~clk;

    function automatic result_word_t advance_clock(input pass_word_t w);
        result_word_t r;
        int unsigned  hh;
        int unsigned  mm;
        int unsigned  ss;
        int unsigned  q;
        int unsigned  total;
        hh = model_secs / 3600;
        mm = (model_secs / 60) % 60;
        ss = model_secs % 60;
        if (w.button_level)
            model_mode = mode_t'(model_mode + 2'd1);
        r = '0;
        r.clock_mode = model_mode;
        case (model_mode)
            MODE_RUNNING:
            begin
                r.seconds_angle    = ANGLE_W'(ss * 3);
                r.minutes_angle    = ANGLE_W'(mm * 3);
                r.hours_angle      = ANGLE_W'((hh * 5) >> 1);
                r.angle_write_mask = MASK_ALL;
                total = model_secs + 1;
            end
            MODE_SET_HOURS:
            begin
                q = (int'(w.dial_sample) * 24 + 512) >> 10;
                r.hours_angle      = ANGLE_W'((q * 15) >> 1);
                r.angle_write_mask = MASK_HOURS;
                total = q * 3600 + mm * 60 + ss;
            end
            MODE_SET_MINUTES:
            begin
                q = (int'(w.dial_sample) * 60 + 512) >> 10;
                r.minutes_angle    = ANGLE_W'(q * 3);
                r.angle_write_mask = MASK_MINUTES;
                total = hh * 3600 + q * 60 + ss;
            end
            default:
            begin
                q = (int'(w.dial_sample) * 60 + 512) >> 10;
                r.seconds_angle    = ANGLE_W'(q * 3);
                r.angle_write_mask = MASK_SECONDS;
                total = hh * 3600 + mm * 60 + q;
            end
        endcase
        // A full day set from the dial folds back to the start of the day.
        model_secs = COUNT_W'(total % SECS_PER_DAY);
        r.time_count = model_secs;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Offers one word, holding it until the core takes it, then records its result.
    task automatic send_word(input pass_word_t w, input bit typed, input result_word_t want);
        result_word_t predicted;
        while ($urandom_range(0, 99) < pass_gap_pct)
        begin
            pass_valid <= 1'b0;
            @(posedge clk);
        end
        pass_valid <= 1'b1;
        pass_word  <= w;
        @(posedge clk);
        while (!pass_ready)
            @(posedge clk);
        predicted = advance_clock(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: check each accepted word, then decide whether to stall next cycle.
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word arrived with none expected");
                mismatch_count++;
            end
            else
            begin
                result_word_t want;
                want = pending_results.pop_front();
                check_field("clock_mode", 32'(want.clock_mode),
                            32'(result_word.clock_mode));
                check_field("time_count", 32'(want.time_count),
                            32'(result_word.time_count));
                check_field("seconds_angle", 32'(want.seconds_angle),
                            32'(result_word.seconds_angle));
                check_field("minutes_angle", 32'(want.minutes_angle),
                            32'(result_word.minutes_angle));
                check_field("hours_angle", 32'(want.hours_angle),
                            32'(result_word.hours_angle));
                check_field("angle_write_mask", 32'(want.angle_write_mask),
                            32'(result_word.angle_write_mask));
            end
        end
        result_ready <= ($urandom_range(0, 99) >= result_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((pass_valid && pass_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("servo_gauge_clock_with_set_modes_core_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        pass_word_t w;
        int unsigned phase;
        clk              = 1'b0;
        rst_n            = 1'b0;
        pass_valid       = 1'b0;
        pass_word        = '0;
        result_ready     = 1'b0;
        model_secs       = '0;
        model_mode       = MODE_RUNNING;
        mismatch_count   = 0;
        pass_gap_pct     = 0;
        result_stall_pct = 0;
        quiet_cycles     = 0;

        // Typed rows walk the dial extremes from midnight; the rest set a time
        // just short of midnight, let it roll over, and push minutes past a day.
        steps = '{
            '{'{1'b0, 10'd0},    1'b1,
              '{MODE_RUNNING, 17'd1, 8'd0, 8'd0, 8'd0, MASK_ALL}},
            '{'{1'b1, 10'd1023}, 1'b1,
              '{MODE_SET_HOURS, 17'd1, 8'd0, 8'd0, 8'd180, MASK_HOURS}},
            '{'{1'b1, 10'd1023}, 1'b1,
              '{MODE_SET_MINUTES, 17'd3601, 8'd0, 8'd180, 8'd0, MASK_MINUTES}},
            '{'{1'b1, 10'd1023}, 1'b1,
              '{MODE_SET_SECONDS, 17'd3660, 8'd180, 8'd0, 8'd0, MASK_SECONDS}},
            '{'{1'b1, 10'd0},    1'b0, NO_WANT},
            '{'{1'b1, 10'd0},    1'b0, NO_WANT},
            '{'{1'b0, 10'd980},  1'b0, NO_WANT},
            '{'{1'b1, 10'd1005}, 1'b0, NO_WANT},
            '{'{1'b1, 10'd1005}, 1'b0, NO_WANT},
            '{'{1'b1, 10'd0},    1'b0, NO_WANT},
            '{'{1'b0, 10'h155},  1'b0, NO_WANT},
            '{'{1'b1, 10'd980},  1'b0, NO_WANT},
            '{'{1'b1, 10'd1023}, 1'b0, NO_WANT},
            '{'{1'b1, 10'd512},  1'b0, NO_WANT},
            '{'{1'b0, 10'h2AA},  1'b0, NO_WANT},
            '{'{1'b1, 10'h2AA},  1'b0, NO_WANT},
            '{'{1'b0, 10'h3FF},  1'b0, NO_WANT},
            '{'{1'b1, 10'd512},  1'b0, NO_WANT},
            '{'{1'b1, 10'd0},    1'b0, NO_WANT},
            '{'{1'b1, 10'd1},    1'b0, NO_WANT},
            '{'{1'b1, 10'd0},    1'b0, NO_WANT}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[i])
            send_word(steps[i].word, steps[i].typed, steps[i].want);

        for (int unsigned n = 0; n < RANDOM_PASSES; n++)
        begin
            phase = (n * 4) / RANDOM_PASSES;
            case (phase)
                0:       begin pass_gap_pct = 0;  result_stall_pct = 0;  end
                1:       begin pass_gap_pct = 58; result_stall_pct = 0;  end
                2:       begin pass_gap_pct = 0;  result_stall_pct = 58; end
                default: begin pass_gap_pct = 14; result_stall_pct = 14; end
            endcase
            w.button_level = ($urandom_range(0, 4) == 0);
            // A third of the dial readings sit near the top, where the set
            // values reach a full day, hour or minute.
            if ($urandom_range(0, 2) == 0)
                w.dial_sample = DIAL_W'($urandom_range(940, 1023));
            else
                w.dial_sample = DIAL_W'($urandom_range(0, 1023));
            send_word(w, 1'b0, NO_WANT);
        end
        pass_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("servo_gauge_clock_with_set_modes_core_tb passed");
        else
            $display("servo_gauge_clock_with_set_modes_core_tb failed");
        $finish;
    end

endmodule

[sim.f]
src/sgc_pkg.sv
src/sgc_input_stage.sv
src/sgc_time_core.sv
src/sgc_output_stage.sv
src/servo_gauge_clock_with_set_modes_core.sv
tb/servo_gauge_clock_with_set_modes_core_tb.sv
